// File: hw/rtl/mafl_pkg.sv
// Shared types, codes and constants for the MAC address filter table.
package mafl_pkg;

   localparam int MAC_W               = 48;
   localparam int CMD_W               = 2;
   localparam int FRAME_TYPE_W        = 2;
   localparam int STATUS_W            = 2;
   localparam int ENTRY_COUNT_W       = 7;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 1;
   localparam int TABLE_DEPTH_DEFAULT = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CHECK  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [FRAME_TYPE_W-1:0] {
      FT_MGMT     = 2'd0,
      FT_CTRL     = 2'd1,
      FT_DATA     = 2'd2,
      FT_RESERVED = 2'd3
   } frame_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_ENABLE   = 3'd0,
      CSR_ALLOW_LIST_MODE = 3'd1,
      CSR_CAPTURE_MGMT    = 3'd2,
      CSR_CAPTURE_CTRL    = 3'd3,
      CSR_CAPTURE_DATA    = 3'd4
   } csr_index_type;

   typedef struct packed {
      cmd_type           command;
      frame_kind_type    frame_type;
      logic [MAC_W-1:0]  receiver_addr;
      logic [MAC_W-1:0]  sender_addr;
      logic              sender_present;
      logic [MAC_W-1:0]  bss_addr;
      logic              bss_present;
      logic [MAC_W-1:0]  entry_mac;
   } req_word_type;

   // Lookup flags from the address table toward the decision logic.
   typedef struct packed {
      logic frame_hit;
      logic entry_hit;
      logic full;
      logic empty;
   } cam_flags_type;

endpackage

// File: hw/rtl/mafl_if.sv
// Channel interfaces: request words, response words and register writes.
interface mafl_req_if import mafl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [FRAME_TYPE_W-1:0] frame_type;
   logic [MAC_W-1:0]        receiver_addr;
   logic [MAC_W-1:0]        sender_addr;
   logic                    sender_present;
   logic [MAC_W-1:0]        bss_addr;
   logic                    bss_present;
   logic [MAC_W-1:0]        entry_mac;

   modport source (output valid, command, frame_type, receiver_addr, sender_addr,
                   sender_present, bss_addr, bss_present, entry_mac,
                   input ready);
   modport sink   (input valid, command, frame_type, receiver_addr, sender_addr,
                   sender_present, bss_addr, bss_present, entry_mac,
                   output ready);
endinterface

interface mafl_rsp_if import mafl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     pass;
   logic [STATUS_W-1:0]      status;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, pass, status, entry_count, input ready);
   modport sink   (input valid, pass, status, entry_count, output ready);
endinterface

interface mafl_csr_if import mafl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/mac_address_filter_table.sv
// Top level of the MAC address filter table with request, response and register channels.
//
// Usage: each word on req_ch carries a command. Check tests a frame against the
// frame-type capture mask and then against the address table; add, remove and
// clear maintain the table. Every request word yields exactly one word on
// rsp_ch with pass, status and the entry count after the command.
// Register writes arrive on csr_ch (always ready); issue them only while no
// request is in flight.
// Path: a word accepted on req_ch is captured in the input register, is decided
// against the table from that register and loads the result register, which
// drives its response on rsp_ch. Throughput: one word per cycle while rsp_ch.ready
// is high, set by the single parallel compare of all entries between the input
// and result registers.
// Table updates land at the same edge as the result, so the next word always
// sees them.
// Reset: valid bits and count clear at once (no sweep), registers return to
// filtering off, block-list mode and all frame types captured.
// Stall: while rsp_ch.ready is low the result register holds; the input
// register still takes one more word, then req_ch.ready drops.
module mac_address_filter_table import mafl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mafl_csr_if.sink   csr_ch,
   mafl_req_if.sink   req_ch,
   mafl_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Configuration registers.
   logic filter_enable_ff, allow_list_mode_ff;
   logic capture_mgmt_ff, capture_ctrl_ff, capture_data_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff   <= 1'b0;
         allow_list_mode_ff <= 1'b0;
         capture_mgmt_ff    <= 1'b1;
         capture_ctrl_ff    <= 1'b1;
         capture_data_ff    <= 1'b1;
      end else if (csr_ch.valid) begin
         // Drop writes to indexes beyond the register list.
         unique case (csr_index_type'(csr_ch.index))
            CSR_FILTER_ENABLE:   filter_enable_ff   <= csr_ch.data[0];
            CSR_ALLOW_LIST_MODE: allow_list_mode_ff <= csr_ch.data[0];
            CSR_CAPTURE_MGMT:    capture_mgmt_ff    <= csr_ch.data[0];
            CSR_CAPTURE_CTRL:    capture_ctrl_ff    <= csr_ch.data[0];
            CSR_CAPTURE_DATA:    capture_data_ff    <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         req_take, advance;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     pass_ff, pass_in;
   status_type               status_ff, status_in;
   logic [ENTRY_COUNT_W-1:0] count_ff, count_in;

   // Advance the input word whenever the result register is free or draining.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      in_word_in.command        = cmd_type'(req_ch.command);
      in_word_in.frame_type     = frame_kind_type'(req_ch.frame_type);
      in_word_in.receiver_addr  = req_ch.receiver_addr;
      in_word_in.sender_addr    = req_ch.sender_addr;
      in_word_in.sender_present = req_ch.sender_present;
      in_word_in.bss_addr       = req_ch.bss_addr;
      in_word_in.bss_present    = req_ch.bss_present;
      in_word_in.entry_mac      = req_ch.entry_mac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= in_word_in;
      end
      if (advance) begin
         pass_ff   <= pass_in;
         status_ff <= status_in;
         count_ff  <= count_in;
      end
   end

   // Address table; it commits the update together with the result.
   cam_flags_type    flags;
   logic [CNT_W-1:0] count_next;

   mafl_cam #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_cam (
      .clock      (clock),
      .reset      (reset),
      .commit     (advance),
      .word       (in_word_ff),
      .flags      (flags),
      .count_next (count_next)
   );

   // Decision logic.
   logic type_ok;

   always_comb begin
      unique case (in_word_ff.frame_type)
         FT_MGMT: type_ok = capture_mgmt_ff;
         FT_CTRL: type_ok = capture_ctrl_ff;
         FT_DATA: type_ok = capture_data_ff;
         default: type_ok = 1'b1;   // reserved type bypasses the mask
      endcase
   end

   always_comb begin
      pass_in   = 1'b0;
      status_in = ST_OK;
      unique case (in_word_ff.command)
         CMD_CHECK: begin
            pass_in = type_ok &&
                      (!filter_enable_ff || flags.empty ||
                       (allow_list_mode_ff ? flags.frame_hit : !flags.frame_hit));
         end
         CMD_ADD: begin
            // Duplicate takes precedence over full.
            if (flags.entry_hit) begin
               status_in = ST_DUPLICATE;
            end else if (flags.full) begin
               status_in = ST_FULL;
            end
         end
         CMD_REMOVE: begin
            if (!flags.entry_hit) begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_in = ENTRY_COUNT_W'(count_next);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pass        = pass_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = count_ff;

endmodule

// File: hw/rtl/mafl_cam.sv
// Address table: entry storage, valid bits, count, parallel match and update.
module mafl_cam import mafl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  req_word_type     word,
   output cam_flags_type    flags,
   output logic [CNT_W-1:0] count_next
);

   logic [MAC_W-1:0]       addr_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic [TABLE_DEPTH-1:0] frame_match, entry_match, free_slots, first_free;
   logic                   add_ok, remove_ok;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         frame_match[i] = valid_ff[i] &&
                          ((addr_ff[i] == word.receiver_addr) ||
                           (word.sender_present && (addr_ff[i] == word.sender_addr)) ||
                           (word.bss_present && (addr_ff[i] == word.bss_addr)));
         entry_match[i] = valid_ff[i] && (addr_ff[i] == word.entry_mac);
      end
   end

   // Isolate the lowest free slot.
   assign free_slots = ~valid_ff;
   assign first_free = free_slots & (~free_slots + TABLE_DEPTH'(1));

   assign flags.frame_hit = |frame_match;
   assign flags.entry_hit = |entry_match;
   assign flags.full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign flags.empty     = (count_ff == '0);

   assign add_ok    = (word.command == CMD_ADD) && !flags.entry_hit && !flags.full;
   assign remove_ok = (word.command == CMD_REMOVE) && flags.entry_hit;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      unique case (word.command)
         CMD_ADD: begin
            if (add_ok) begin
               valid_in = valid_ff | first_free;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (remove_ok) begin
               valid_in = valid_ff & ~entry_match;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            valid_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (commit && add_ok && first_free[i]) begin
            addr_ff[i] <= word.entry_mac;
         end
      end
   end

endmodule

// File: tb/filter_checker.sv
`timescale 1ns / 100ps
// Response checker: mirrors the address table and compares every response word.
module filter_checker import mafl_pkg::*; #(
   parameter int DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mafl_csr_if  csr_ch,
   mafl_req_if  req_ch,
   mafl_rsp_if  rsp_ch,
   output int   fail_count,
   output int   verdicts_waiting
);

   typedef struct packed {
      logic                     pass;
      status_type               status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } verdict_type;

   bit [MAC_W-1:0] addr_mem [DEPTH];
   bit             slot_used [DEPTH];
   int             used_count;
   logic           filter_on, allow_mode, keep_mgmt, keep_ctrl, keep_data;
   verdict_type    verdict_q [$];

   initial fail_count = 0;

   function automatic int find_mac(logic [MAC_W-1:0] mac);
      for (int i = 0; i < DEPTH; i++)
         if (slot_used[i] && addr_mem[i] == mac) return i;
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int i = 0; i < DEPTH; i++)
         if (!slot_used[i]) return i;
      return -1;
   endfunction

   function automatic logic frame_passes(req_word_type w);
      logic hit;
      hit = 1'b0;
      case (w.frame_type)
         FT_MGMT: if (!keep_mgmt) return 1'b0;
         FT_CTRL: if (!keep_ctrl) return 1'b0;
         FT_DATA: if (!keep_data) return 1'b0;
         default: ;
      endcase
      if (!filter_on || used_count == 0) return 1'b1;
      for (int i = 0; i < DEPTH; i++)
         if (slot_used[i] && (addr_mem[i] == w.receiver_addr ||
                              (w.sender_present && addr_mem[i] == w.sender_addr) ||
                              (w.bss_present && addr_mem[i] == w.bss_addr)))
            hit = 1'b1;
      return allow_mode ? hit : !hit;
   endfunction

   // Apply one request word to the mirrored table and return its response.
   function automatic verdict_type apply_word(req_word_type w);
      verdict_type v;
      int          slot;
      v.pass   = 1'b0;
      v.status = ST_OK;
      case (w.command)
         CMD_CHECK: v.pass = frame_passes(w);
         CMD_ADD: begin
            slot = find_mac(w.entry_mac);
            if (slot >= 0) v.status = ST_DUPLICATE;
            else if (used_count >= DEPTH) v.status = ST_FULL;
            else begin
               slot            = first_free_slot();
               slot_used[slot] = 1'b1;
               addr_mem[slot]  = w.entry_mac;
               used_count++;
            end
         end
         CMD_REMOVE: begin
            slot = find_mac(w.entry_mac);
            if (slot < 0) v.status = ST_NOT_FOUND;
            else begin
               slot_used[slot] = 1'b0;
               used_count--;
            end
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
            used_count = 0;
         end
      endcase
      v.entry_count = ENTRY_COUNT_W'(used_count);
      return v;
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      verdict_type  want;
      req_word_type w;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
         used_count = 0;
         filter_on  = 1'b0;
         allow_mode = 1'b0;
         keep_mgmt  = 1'b1;
         keep_ctrl  = 1'b1;
         keep_data  = 1'b1;
         verdict_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               $display("%0t: response word with none expected, pass %0b status %0d count %0d",
                        $time, rsp_ch.pass, rsp_ch.status, rsp_ch.entry_count);
            end else begin
               want = verdict_q.pop_front();
               compare_field("pass", 8'(want.pass), 8'(rsp_ch.pass));
               compare_field("status", 8'(want.status), 8'(rsp_ch.status));
               compare_field("entry_count", 8'(want.entry_count), 8'(rsp_ch.entry_count));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_FILTER_ENABLE:   filter_on  = csr_ch.data[0];
               CSR_ALLOW_LIST_MODE: allow_mode = csr_ch.data[0];
               CSR_CAPTURE_MGMT:    keep_mgmt  = csr_ch.data[0];
               CSR_CAPTURE_CTRL:    keep_ctrl  = csr_ch.data[0];
               CSR_CAPTURE_DATA:    keep_data  = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            w.command        = cmd_type'(req_ch.command);
            w.frame_type     = frame_kind_type'(req_ch.frame_type);
            w.receiver_addr  = req_ch.receiver_addr;
            w.sender_addr    = req_ch.sender_addr;
            w.sender_present = req_ch.sender_present;
            w.bss_addr       = req_ch.bss_addr;
            w.bss_present    = req_ch.bss_present;
            w.entry_mac      = req_ch.entry_mac;
            verdict_q = {verdict_q, apply_word(w)};
         end
      end
      verdicts_waiting = verdict_q.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the filter table testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
   import mafl_pkg::*;

   localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on any channel
   localparam int DRAIN_CYCLES = 6;     // settling margin after the last response
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_WORDS  = 105;
   localparam int FILL_WORDS   = 120;
   localparam int POOL_SIZE    = 96;
   localparam int NEAR_SPAN    = 24;    // small address set so checks hit often
   localparam int IDLE_PCT     = 22;
   // Register indexes past the end of the list; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [MAC_W-1:0]       MAC_ZERO     = '0;
   localparam logic [MAC_W-1:0]       MAC_ONES     = '1;

   logic clock;
   logic reset;
   logic calm;              // high while neither side idles
   int   fail_count;
   int   verdicts_waiting;
   int   quiet_cycles;
   int   fill_cursor;
   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   mafl_csr_if csr_ch ();
   mafl_req_if req_ch ();
   mafl_rsp_if rsp_ch ();

   mac_address_filter_table #(.TABLE_DEPTH(TABLE_DEPTH_DEFAULT)) dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   filter_checker #(.DEPTH(TABLE_DEPTH_DEFAULT)) verdict_monitor (
      .clock            (clock),
      .reset            (reset),
      .csr_ch           (csr_ch),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .fail_count       (fail_count),
      .verdicts_waiting (verdicts_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the response side at random; hold ready high through calm stretches.
   always @(negedge clock) begin
      rsp_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: end the run if no word moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Mostly pool addresses so that adds collide and checks hit; the rest fully random.
   function automatic logic [MAC_W-1:0] pick_mac(int span);
      if ($urandom_range(99) < 75) return mac_pool[$urandom_range(span - 1)];
      return MAC_W'({$urandom, $urandom});
   endfunction

   function automatic req_word_type frame_word(frame_kind_type ft, logic [MAC_W-1:0] a1,
                                               logic [MAC_W-1:0] a2, logic p2,
                                               logic [MAC_W-1:0] a3, logic p3);
      req_word_type w;
      w.command        = CMD_CHECK;
      w.frame_type     = ft;
      w.receiver_addr  = a1;
      w.sender_addr    = a2;
      w.sender_present = p2;
      w.bss_addr       = a3;
      w.bss_present    = p3;
      w.entry_mac      = MAC_W'({$urandom, $urandom});
      return w;
   endfunction

   // Table command; frame fields get random filler the block must ignore.
   function automatic req_word_type entry_word(cmd_type cmd, logic [MAC_W-1:0] mac);
      req_word_type w;
      w           = frame_word(frame_kind_type'($urandom_range(3)),
                               MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}),
                               1'($urandom_range(1)), MAC_W'({$urandom, $urandom}),
                               1'($urandom_range(1)));
      w.command   = cmd;
      w.entry_mac = mac;
      return w;
   endfunction

   function automatic req_word_type random_check(int span);
      return frame_word(frame_kind_type'($urandom_range(3)), pick_mac(span), pick_mac(span),
                        1'($urandom_range(1)), pick_mac(span), 1'($urandom_range(1)));
   endfunction

   // Present one request word and hold it until the block takes it.
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.command        = w.command;
      req_ch.frame_type     = w.frame_type;
      req_ch.receiver_addr  = w.receiver_addr;
      req_ch.sender_addr    = w.sender_addr;
      req_ch.sender_present = w.sender_present;
      req_ch.bss_addr       = w.bss_addr;
      req_ch.bss_present    = w.bss_present;
      req_ch.entry_mac      = w.entry_mac;
      req_ch.valid          = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drain all outstanding responses, then write one register.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic value);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (verdicts_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Register settings per phase, bit i for register index i.
   function automatic logic [4:0] phase_setting(int p);
      case (p)
         0:       return 5'b11101;  // filtering on, block list, all types
         1:       return 5'b11111;  // allow list
         2:       return 5'b11111;
         3:       return 5'b00000;  // everything off
         5:       return 5'b11101;
         7:       return 5'b11110;  // allow list set but filtering off
         default: return 5'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [4:0]   setting;
      logic         fill;
      int           words;
      int           roll;
      req_word_type w;

      reset                 = 1'b1;
      calm                  = 1'b0;
      quiet_cycles          = 0;
      fill_cursor           = 0;
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_CHECK;
      req_ch.frame_type     = FT_MGMT;
      req_ch.receiver_addr  = '0;
      req_ch.sender_addr    = '0;
      req_ch.sender_present = 1'b0;
      req_ch.bss_addr       = '0;
      req_ch.bss_present    = 1'b0;
      req_ch.entry_mac      = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_FILTER_ENABLE;
      csr_ch.data           = '0;
      rsp_ch.ready          = 1'b0;

      mac_pool[0] = MAC_ZERO;
      mac_pool[1] = MAC_ONES;
      for (int i = 2; i < POOL_SIZE; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, reset settings: filtering off, every frame type passes.
      send_word(random_check(POOL_SIZE));
      send_word(frame_word(FT_MGMT, MAC_ZERO, MAC_ONES, 1'b1, MAC_ZERO, 1'b1));
      send_word(frame_word(FT_CTRL, MAC_ONES, MAC_ZERO, 1'b0, MAC_ONES, 1'b0));
      send_word(frame_word(FT_DATA, mac_pool[2], mac_pool[3], 1'b1, mac_pool[4], 1'b0));
      send_word(frame_word(FT_RESERVED, mac_pool[5], mac_pool[6], 1'b0, mac_pool[7], 1'b1));
      // Remove from an empty table, duplicate add, clear and refill.
      send_word(entry_word(CMD_REMOVE, MAC_ZERO));
      send_word(entry_word(CMD_ADD, MAC_ZERO));
      send_word(entry_word(CMD_ADD, MAC_ONES));
      send_word(entry_word(CMD_ADD, MAC_ZERO));
      send_word(entry_word(CMD_CLEAR, MAC_ONES));
      send_word(entry_word(CMD_ADD, MAC_ZERO));
      send_word(entry_word(CMD_ADD, MAC_ONES));

      // Block list: a hit on any present address drops; an absent one is not compared.
      write_csr(CSR_FILTER_ENABLE, 1'b1);
      send_word(frame_word(FT_DATA, MAC_ZERO, mac_pool[2], 1'b1, mac_pool[3], 1'b1));
      send_word(frame_word(FT_DATA, mac_pool[2], MAC_ONES, 1'b1, mac_pool[3], 1'b1));
      send_word(frame_word(FT_DATA, mac_pool[2], MAC_ONES, 1'b0, mac_pool[3], 1'b1));
      send_word(frame_word(FT_MGMT, mac_pool[2], mac_pool[3], 1'b0, MAC_ONES, 1'b1));
      send_word(frame_word(FT_MGMT, mac_pool[2], mac_pool[3], 1'b0, MAC_ONES, 1'b0));

      // Allow list: only a hit passes.
      write_csr(CSR_ALLOW_LIST_MODE, 1'b1);
      send_word(frame_word(FT_CTRL, mac_pool[2], mac_pool[3], 1'b1, mac_pool[4], 1'b1));
      send_word(frame_word(FT_CTRL, MAC_ONES, mac_pool[3], 1'b0, mac_pool[4], 1'b0));

      // Mask off every type; the reserved type still goes through.
      write_csr(CSR_CAPTURE_MGMT, 1'b0);
      write_csr(CSR_CAPTURE_CTRL, 1'b0);
      write_csr(CSR_CAPTURE_DATA, 1'b0);
      write_csr(CSR_SPARE_LO, 1'b0);
      write_csr(CSR_SPARE_HI, 1'b1);
      send_word(frame_word(FT_MGMT, MAC_ZERO, mac_pool[3], 1'b0, mac_pool[4], 1'b0));
      send_word(frame_word(FT_CTRL, MAC_ZERO, mac_pool[3], 1'b0, mac_pool[4], 1'b0));
      send_word(frame_word(FT_DATA, MAC_ZERO, mac_pool[3], 1'b0, mac_pool[4], 1'b0));
      send_word(frame_word(FT_RESERVED, MAC_ZERO, mac_pool[3], 1'b0, mac_pool[4], 1'b0));
      send_word(entry_word(CMD_REMOVE, MAC_ONES));
      send_word(entry_word(CMD_REMOVE, MAC_ONES));
      send_word(entry_word(CMD_CLEAR, MAC_ZERO));
      send_word(frame_word(FT_RESERVED, MAC_ZERO, MAC_ONES, 1'b1, MAC_ZERO, 1'b1));

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         setting = phase_setting(p);
         for (int r = 0; r <= CSR_CAPTURE_DATA; r++)
            write_csr(CSR_INDEX_W'(r), setting[r]);
         fill  = (p == 2) || (p == 5);
         calm  = (p == 3);
         words = fill ? FILL_WORDS : PHASE_WORDS;
         for (int n = 0; n < words; n++) begin
            roll = $urandom_range(99);
            if (fill) begin
               // Walk the pool to fill the table, with repeats and a few removes.
               if (roll < 75) begin
                  if ($urandom_range(3) != 0) begin
                     w           = entry_word(CMD_ADD, mac_pool[fill_cursor]);
                     fill_cursor = (fill_cursor + 1) % POOL_SIZE;
                  end else
                     w = entry_word(CMD_ADD, mac_pool[$urandom_range(POOL_SIZE - 1)]);
               end else if (roll < 80)
                  w = entry_word(CMD_REMOVE, pick_mac(POOL_SIZE));
               else
                  w = random_check(POOL_SIZE);
            end else begin
               if (roll < 2)
                  w = entry_word(CMD_CLEAR, pick_mac(NEAR_SPAN));
               else if (roll < 22)
                  w = entry_word(CMD_ADD, pick_mac(NEAR_SPAN));
               else if (roll < 37)
                  w = entry_word(CMD_REMOVE, pick_mac(NEAR_SPAN));
               else
                  w = random_check(NEAR_SPAN);
            end
            send_word(w);
         end
      end
      calm = 1'b0;

      // Drop valid, wait for every response, then let the pipeline settle.
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (verdicts_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
